// ===== rtl/core/mfs_pkg.sv =====
// shared types, register indexes and constants for the motor fault supervisor
// no dependencies
`default_nettype none

package mfs_pkg;

    localparam int VOLT_W  = 10;
    localparam int CUR_W   = 16;
    localparam int TEMP_W  = 8;
    localparam int CNT_W   = 16;
    localparam int HOT_W   = 8;
    localparam int FAULT_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // fault bit positions
    localparam int FB_OC    = 0;
    localparam int FB_START = 1;
    localparam int FB_UV    = 3;
    localparam int FB_OT    = 4;
    localparam int FB_OV    = 5;
    localparam int FB_OTHER = 6;

    localparam logic [HOT_W-1:0] TEMP_PERSIST_TICKS = 8'd10;

    // peak * 1000 / 1414 as peak * ceil(2^29 / 707) * 500 >> 29, exact for 10 bit peak
    localparam int RMS_SHIFT = 29;
    localparam int RMS_PROD_W = 39;
    localparam logic [RMS_PROD_W-1:0] RMS_MAGIC = 39'd379682500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UV_LIMIT       = 3'd0,
        CFG_OV_LIMIT       = 3'd1,
        CFG_UV_RECOV_LOW   = 3'd2,
        CFG_UV_RECOV_HIGH  = 3'd3,
        CFG_OV_RECOV_HIGH  = 3'd4,
        CFG_VOLT_PERSIST   = 3'd5,
        CFG_OC_LIMIT       = 3'd6,
        CFG_OT_LIMIT       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [VOLT_W-1:0]        uv_limit;
        logic [VOLT_W-1:0]        ov_limit;
        logic [VOLT_W-1:0]        uv_recov_low;
        logic [VOLT_W-1:0]        uv_recov_high;
        logic [VOLT_W-1:0]        ov_recov_high;
        logic [CNT_W-1:0]         volt_persist;
        logic [CUR_W-1:0]         oc_limit;
        logic signed [TEMP_W-1:0] ot_limit;
    } t_cfg;

    function automatic logic [VOLT_W-1:0] peak_to_rms(input logic [VOLT_W-1:0] peak);
        logic [RMS_PROD_W-1:0] prod;
        prod = RMS_PROD_W'(peak) * RMS_MAGIC;
        return prod[RMS_PROD_W-1:RMS_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/motor_fault_supervisor.sv =====
// top level of the motor fault supervisor: input stage, fault evaluation, result register
// depends on mfs_pkg and mfs_cfg_regs
`default_nettype none

// One beat in gives one beat out. A beat is taken every cycle when the output side keeps up;
// the peak-to-RMS multiply runs into the input register, then the threshold compares and
// counter updates run into the result register. While a result waits, the input register
// still takes one beat, then the block stalls until the result is taken.
// Configuration writes are registered and must land while the block is idle.
module motor_fault_supervisor
    import mfs_pkg::*;
#(
    parameter logic [HOT_W-1:0] TEMP_PERSIST = TEMP_PERSIST_TICKS
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // bus_voltage_peak[9:0], current_code[25:10], temperature_c[33:26],
    // startup_fault[34], other_fault[35], zero pad[39:36]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // fault_bits[6:0], error_mode_request[7], resume_request[8],
    // overcurrent_trip[9], rms_voltage[19:10], zero pad[23:20]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;

    mfs_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_cfg_ready = 1'b1;

    // input stage
    logic                     r_in_valid;
    logic [VOLT_W-1:0]        r_in_rms;
    logic [CUR_W-1:0]         r_in_cur;
    logic signed [TEMP_W-1:0] r_in_temp;
    logic                     r_in_start;
    logic                     r_in_other;

    // state
    logic [FAULT_W-1:0] r_flags;
    logic [CNT_W-1:0]   r_low_cnt;
    logic [CNT_W-1:0]   r_high_cnt;
    logic [HOT_W-1:0]   r_hot_cnt;

    // result register
    logic               r_out_valid;
    logic [FAULT_W-1:0] r_out_bits;
    logic               r_out_err;
    logic               r_out_resume;
    logic               r_out_trip;
    logic [VOLT_W-1:0]  r_out_rms;

    logic               advance;
    logic               in_beat;
    logic [FAULT_W-1:0] n_flags;
    logic [CNT_W-1:0]   n_low_cnt;
    logic [CNT_W-1:0]   n_high_cnt;
    logic [HOT_W-1:0]   n_hot_cnt;
    logic               n_resume;
    logic               n_trip;
    logic [CNT_W-1:0]   low_inc;
    logic [CNT_W-1:0]   high_inc;
    logic [HOT_W-1:0]   hot_inc;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign low_inc  = r_low_cnt + 16'd1;
    assign high_inc = r_high_cnt + 16'd1;
    assign hot_inc  = r_hot_cnt + 8'd1;

    always_comb begin
        n_flags    = r_flags;
        n_low_cnt  = '0;
        n_high_cnt = '0;
        n_hot_cnt  = r_hot_cnt;
        n_resume   = 1'b0;
        n_trip     = 1'b0;

        if (r_in_rms < cfg.uv_limit) begin
            if (low_inc > cfg.volt_persist) begin
                n_flags[FB_UV] = 1'b1;
            end else begin
                n_low_cnt = low_inc;
            end
        end

        if (r_in_rms > cfg.ov_limit) begin
            if (high_inc > cfg.volt_persist) begin
                n_flags[FB_OV] = 1'b1;
            end else begin
                n_high_cnt = high_inc;
            end
        end

        // recovery sees bits set above in the same beat
        if (r_in_rms > cfg.uv_recov_low && r_in_rms < cfg.uv_recov_high && n_flags[FB_UV]) begin
            n_flags[FB_UV] = 1'b0;
            n_resume       = 1'b1;
        end

        if (r_in_rms < cfg.ov_recov_high && r_in_rms > cfg.uv_limit && n_flags[FB_OV]) begin
            n_flags[FB_OV] = 1'b0;
            n_resume       = 1'b1;
        end

        if (r_in_cur > cfg.oc_limit) begin
            n_trip         = 1'b1;
            n_flags[FB_OC] = 1'b1;
        end
        if (r_in_start) begin
            n_flags[FB_START] = 1'b1;
        end
        if (r_in_other) begin
            n_flags[FB_OTHER] = 1'b1;
        end

        if (r_in_temp > cfg.ot_limit) begin
            if (hot_inc > TEMP_PERSIST) begin
                n_hot_cnt      = '0;
                n_flags[FB_OT] = 1'b1;
            end else begin
                n_hot_cnt = hot_inc;
            end
        end else if (r_in_temp < cfg.ot_limit) begin
            n_hot_cnt = '0;
            if (n_flags[FB_OT]) begin
                n_flags[FB_OT] = 1'b0;
                n_resume       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_beat) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_rms   <= peak_to_rms(s_axis_tdata[9:0]);
            r_in_cur   <= s_axis_tdata[25:10];
            r_in_temp  <= $signed(s_axis_tdata[33:26]);
            r_in_start <= s_axis_tdata[34];
            r_in_other <= s_axis_tdata[35];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_low_cnt   <= '0;
            r_high_cnt  <= '0;
            r_hot_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_flags     <= n_flags;
                r_low_cnt   <= n_low_cnt;
                r_high_cnt  <= n_high_cnt;
                r_hot_cnt   <= n_hot_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_bits   <= n_flags;
            r_out_err    <= |n_flags;
            r_out_resume <= n_resume;
            r_out_trip   <= n_trip;
            r_out_rms    <= r_in_rms;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_rms, r_out_trip, r_out_resume, r_out_err, r_out_bits};

`ifndef SYNTHESIS
    a_err_matches_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_err == (r_out_bits != '0)))
        else $error("error mode request disagrees with fault bits");

    a_trip_sets_oc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_trip) |-> r_out_bits[FB_OC])
        else $error("overcurrent trip without overcurrent bit");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_flags) && $stable(r_low_cnt) && $stable(r_hot_cnt)))
        else $error("supervisor state changed without a beat");

    a_spare_bit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags[2] == 1'b0)
        else $error("unused fault bit set");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mfs_cfg_regs.sv =====
// threshold register file of the motor fault supervisor
// depends on mfs_pkg
`default_nettype none

module mfs_cfg_regs
    import mfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.uv_limit      <= 10'd135;
            r_cfg.ov_limit      <= 10'd295;
            r_cfg.uv_recov_low  <= 10'd140;
            r_cfg.uv_recov_high <= 10'd290;
            r_cfg.ov_recov_high <= 10'd265;
            r_cfg.volt_persist  <= 16'd2000;
            r_cfg.oc_limit      <= 16'd26809;
            r_cfg.ot_limit      <= 8'sd60;
        end else if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_UV_LIMIT:      r_cfg.uv_limit      <= i_wr_data[VOLT_W-1:0];
                CFG_OV_LIMIT:      r_cfg.ov_limit      <= i_wr_data[VOLT_W-1:0];
                CFG_UV_RECOV_LOW:  r_cfg.uv_recov_low  <= i_wr_data[VOLT_W-1:0];
                CFG_UV_RECOV_HIGH: r_cfg.uv_recov_high <= i_wr_data[VOLT_W-1:0];
                CFG_OV_RECOV_HIGH: r_cfg.ov_recov_high <= i_wr_data[VOLT_W-1:0];
                CFG_VOLT_PERSIST:  r_cfg.volt_persist  <= i_wr_data[CNT_W-1:0];
                CFG_OC_LIMIT:      r_cfg.oc_limit      <= i_wr_data[CUR_W-1:0];
                CFG_OT_LIMIT:      r_cfg.ot_limit      <= $signed(i_wr_data[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire
